[hdl/stcx_pkg.sv]
// Shared types, constants and the square root step for the segment-to-cylinder transform.
package stcx_pkg;

   localparam int ROOT_BITS    = 32;
   localparam int RAD_BITS     = 2 * ROOT_BITS;
   localparam int REM_BITS     = ROOT_BITS + 2;
   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_W     = 36;
   localparam int ACC_BITS     = 24;
   localparam int CORDIC_STEPS = 22;

   localparam logic signed [ACC_BITS-1:0] QUARTER_TURN = 24'sd2949120;
   localparam logic signed [ACC_BITS-1:0] HALF_TURN    = 24'sd5898240;
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF   = 24'sd128;

   // atan(2^-i) in units of 1/32768 degree
   localparam logic signed [ACC_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      24'sd1474560, 24'sd870484, 24'sd459940, 24'sd233473, 24'sd117189, 24'sd58652,
      24'sd29333, 24'sd14667, 24'sd7334, 24'sd3667, 24'sd1833, 24'sd917, 24'sd458,
      24'sd229, 24'sd115, 24'sd57, 24'sd29, 24'sd14, 24'sd7, 24'sd4, 24'sd2, 24'sd1
   };

   typedef struct packed {
      logic degen;
      logic dz_pos;
      logic dz_zero;
      logic sxy_zero;
   } flags_type;

   typedef struct packed {
      logic [RAD_BITS-1:0]  rad;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
   } root_step_type;

   // One digit of a restoring square root: bring down two radicand bits, try a one
   function automatic root_step_type sqrt_step(root_step_type cur);
      root_step_type nxt;
      logic [REM_BITS-1:0] r2;
      logic [REM_BITS-1:0] t;
      logic ge;
      r2 = {cur.rem[ROOT_BITS-1:0], cur.rad[RAD_BITS-1 -: 2]};
      t  = {cur.root, 2'b01};
      ge = (r2 >= t);
      nxt.rad  = cur.rad << 2;
      nxt.rem  = ge ? (r2 - t) : r2;
      nxt.root = {cur.root[ROOT_BITS-2:0], ge};
      return nxt;
   endfunction

endpackage

[hdl/stcx_if.sv]
// Valid/ready channel interfaces for segment requests and placement responses.
interface stcx_req_if #(parameter int COORD_BITS = 24);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] start_z;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic signed [COORD_BITS-1:0] end_z;

   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   input ready);
   modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   output ready);
endinterface

interface stcx_rsp_if #(parameter int COORD_BITS = 24);
   logic valid;
   logic ready;
   logic [COORD_BITS:0]              length;
   logic signed [15:0]               angle;
   logic signed [2*COORD_BITS+1:0]   axis_x;
   logic signed [2*COORD_BITS+1:0]   axis_y;
   logic                             degenerate;

   modport source (output valid, length, angle, axis_x, axis_y, degenerate, input ready);
   modport sink   (input valid, length, angle, axis_x, axis_y, degenerate, output ready);
endinterface

[hdl/segment_to_cylinder_transform.sv]
// Top level: segment endpoints in, cylinder length, rotation angle and axis out.
//
// Usage: send one segment per beat on req_bus (start and end points, signed
// Q12.12 at the default width). Each beat yields exactly one beat on rsp_bus:
// the rounded length, the angle in 1/128 degree (negated when dz is not
// positive), the axis components -dy*dz and dx*dz, and a degenerate flag for
// a zero-length segment, which also forces the angle to zero.
// The pipeline has 3 front stages (differences, squares, sums), 32 square
// root stages (one root bit each, length and horizontal extent side by side),
// 22 CORDIC stages (one rotation each) and the output register.
// Throughput is one beat per cycle unless the receiver stalls; the rate is set
// by the single enable that advances every stage together.
// When the receiver stalls with a response waiting, the whole pipeline holds
// and req_bus.ready falls; nothing is dropped or duplicated. A request can be
// taken in the same cycle that the waiting response is taken.
// Reset (synchronous, active high) clears every valid bit; the pipeline is
// empty and ready the cycle after.
module segment_to_cylinder_transform #(
   parameter int COORD_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   stcx_req_if.sink   req_bus,
   stcx_rsp_if.source rsp_bus
);
   localparam int D   = COORD_BITS + 1;
   localparam int AB  = 2 * D;
   localparam int H   = 31 - COORD_BITS;
   localparam int W   = stcx_pkg::CORDIC_W;
   localparam int A   = stcx_pkg::ACC_BITS;
   localparam int SQW = 2 * AB + D + $bits(stcx_pkg::flags_type);
   localparam int CSW = D + 2 * AB + $bits(stcx_pkg::flags_type);

   logic en;
   logic fr_valid, sq_valid, co_valid;
   logic [stcx_pkg::RAD_BITS-1:0] rad_a, rad_b;
   logic signed [AB-1:0] fr_axx, fr_axy, sq_axx, sq_axy, co_axx, co_axy;
   logic [D-1:0] fr_az, sq_az;
   stcx_pkg::flags_type fr_fl, sq_fl, co_fl;
   logic [stcx_pkg::ROOT_BITS-1:0] root_a, root_b;
   logic [stcx_pkg::REM_BITS-1:0] rem_a;
   logic [SQW-1:0] sq_side;
   logic [CSW-1:0] co_side_in, co_side;
   logic [D-1:0] len_in, co_len;
   logic signed [W-1:0] cx_in, cy_in;
   logic signed [A-1:0] co_acc, phi, theta, mag_full;
   logic signed [stcx_pkg::ANGLE_BITS-1:0] mag, angle_in;

   logic out_v_ff;
   logic [D-1:0] len_ff;
   logic signed [stcx_pkg::ANGLE_BITS-1:0] angle_ff;
   logic signed [AB-1:0] axx_ff, axy_ff;
   logic degen_ff;

   // one enable moves every stage; hold all while a response waits unread
   assign en = !out_v_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   stcx_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_bus.valid),
      .start_x(req_bus.start_x), .start_y(req_bus.start_y), .start_z(req_bus.start_z),
      .end_x(req_bus.end_x), .end_y(req_bus.end_y), .end_z(req_bus.end_z),
      .out_valid(fr_valid), .rad_a(rad_a), .rad_b(rad_b),
      .axis_x(fr_axx), .axis_y(fr_axy), .az(fr_az), .flags(fr_fl)
   );

   stcx_sqrt #(.SIDE_W(SQW)) u_sqrt (
      .clock(clock), .reset(reset), .en(en), .in_valid(fr_valid),
      .rad_a(rad_a), .rad_b(rad_b), .side_in({fr_axx, fr_axy, fr_az, fr_fl}),
      .out_valid(sq_valid), .root_a(root_a), .rem_a(rem_a), .root_b(root_b),
      .side_out(sq_side)
   );

   assign {sq_axx, sq_axy, sq_az, sq_fl} = sq_side;

   // round the length up when the remainder exceeds the root
   assign len_in = D'(root_a + stcx_pkg::ROOT_BITS'(rem_a > stcx_pkg::REM_BITS'(root_a)));

   assign cx_in      = W'(sq_az) << H;
   assign cy_in      = W'(root_b);
   assign co_side_in = {len_in, sq_axx, sq_axy, sq_fl};

   stcx_cordic #(.SIDE_W(CSW)) u_cordic (
      .clock(clock), .reset(reset), .en(en), .in_valid(sq_valid),
      .x_in(cx_in), .y_in(cy_in), .side_in(co_side_in),
      .out_valid(co_valid), .acc(co_acc), .side_out(co_side)
   );

   assign {co_len, co_axx, co_axy, co_fl} = co_side;

   // pick the polar angle, fold for dz not positive, round to 1/128 degree
   always_comb begin
      if (co_fl.dz_zero) begin
         phi = stcx_pkg::QUARTER_TURN;
      end else if (co_fl.sxy_zero) begin
         phi = '0;
      end else if (co_acc < 0) begin
         phi = '0;
      end else if (co_acc > stcx_pkg::QUARTER_TURN) begin
         phi = stcx_pkg::QUARTER_TURN;
      end else begin
         phi = co_acc;
      end
      theta    = co_fl.dz_pos ? phi : (stcx_pkg::HALF_TURN - phi);
      mag_full = (theta + stcx_pkg::ROUND_HALF) >>> 8;
      mag      = mag_full[stcx_pkg::ANGLE_BITS-1:0];
      if (co_fl.degen) begin
         angle_in = '0;
      end else if (co_fl.dz_pos) begin
         angle_in = mag;
      end else begin
         angle_in = -mag;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= co_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len_ff   <= co_len;
         angle_ff <= angle_in;
         axx_ff   <= co_axx;
         axy_ff   <= co_axy;
         degen_ff <= co_fl.degen;
      end
   end

   assign rsp_bus.valid      = out_v_ff;
   assign rsp_bus.length     = len_ff;
   assign rsp_bus.angle      = angle_ff;
   assign rsp_bus.axis_x     = axx_ff;
   assign rsp_bus.axis_y     = axy_ff;
   assign rsp_bus.degenerate = degen_ff;
endmodule

[hdl/stcx_front.sv]
// Front stages: coordinate differences, squares, axis products and radicand sums.
module stcx_front #(
   parameter int COORD_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] start_z,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   input  logic signed [COORD_BITS-1:0] end_z,
   output logic out_valid,
   output logic [stcx_pkg::RAD_BITS-1:0] rad_a,
   output logic [stcx_pkg::RAD_BITS-1:0] rad_b,
   output logic signed [2*COORD_BITS+1:0] axis_x,
   output logic signed [2*COORD_BITS+1:0] axis_y,
   output logic [COORD_BITS:0] az,
   output stcx_pkg::flags_type flags
);
   localparam int D  = COORD_BITS + 1;
   localparam int AB = 2 * D;
   localparam int H  = 31 - COORD_BITS;

   logic signed [D-1:0] dx_in, dy_in, dz_in;
   logic signed [D-1:0] dx1_ff, dy1_ff, dz1_ff;
   logic [D-1:0] ax1_ff, ay1_ff, az1_ff;
   stcx_pkg::flags_type fl1_ff, fl2_ff, fl3_ff;
   logic v1_ff, v2_ff, v3_ff;
   logic [AB-1:0] sqx2_ff, sqy2_ff, sqz2_ff;
   logic signed [AB-1:0] pyz_in, pxz_in;
   logic signed [AB-1:0] axx2_ff, axy2_ff, axx3_ff, axy3_ff;
   logic [D-1:0] az2_ff, az3_ff;
   logic [AB:0] sxy_in;
   logic [AB+1:0] s_in;
   logic [stcx_pkg::RAD_BITS-1:0] rada3_ff, radb3_ff;

   // differences, exact in one more bit
   assign dx_in = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
   assign dy_in = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
   assign dz_in = {end_z[COORD_BITS-1], end_z} - {start_z[COORD_BITS-1], start_z};

   assign pyz_in = dy1_ff * dz1_ff;
   assign pxz_in = dx1_ff * dz1_ff;
   assign sxy_in = {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
   assign s_in   = {1'b0, sxy_in} + {2'b00, sqz2_ff};

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage 1: differences, magnitudes and flags
   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff <= dx_in;
         dy1_ff <= dy_in;
         dz1_ff <= dz_in;
         ax1_ff <= dx_in[D-1] ? D'(-dx_in) : D'(dx_in);
         ay1_ff <= dy_in[D-1] ? D'(-dy_in) : D'(dy_in);
         az1_ff <= dz_in[D-1] ? D'(-dz_in) : D'(dz_in);
         fl1_ff.degen    <= (dx_in == '0) && (dy_in == '0) && (dz_in == '0);
         fl1_ff.dz_pos   <= !dz_in[D-1] && (dz_in != '0);
         fl1_ff.dz_zero  <= (dz_in == '0);
         fl1_ff.sxy_zero <= (dx_in == '0) && (dy_in == '0);
      end
   end

   // stage 2: squares and axis products
   always_ff @(posedge clock) begin
      if (en) begin
         sqx2_ff <= ax1_ff * ax1_ff;
         sqy2_ff <= ay1_ff * ay1_ff;
         sqz2_ff <= az1_ff * az1_ff;
         axx2_ff <= -pyz_in;
         axy2_ff <= pxz_in;
         az2_ff  <= az1_ff;
         fl2_ff  <= fl1_ff;
      end
   end

   // stage 3: radicands for length and horizontal extent
   always_ff @(posedge clock) begin
      if (en) begin
         rada3_ff <= stcx_pkg::RAD_BITS'(s_in);
         radb3_ff <= stcx_pkg::RAD_BITS'(sxy_in) << (2 * H);
         axx3_ff  <= axx2_ff;
         axy3_ff  <= axy2_ff;
         az3_ff   <= az2_ff;
         fl3_ff   <= fl2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign rad_a     = rada3_ff;
   assign rad_b     = radb3_ff;
   assign axis_x    = axx3_ff;
   assign axis_y    = axy3_ff;
   assign az        = az3_ff;
   assign flags     = fl3_ff;
endmodule

[hdl/stcx_sqrt.sv]
// Two-lane pipelined square root, one result bit per stage, with a carried sideband.
module stcx_sqrt #(
   parameter int SIDE_W = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [stcx_pkg::RAD_BITS-1:0] rad_a,
   input  logic [stcx_pkg::RAD_BITS-1:0] rad_b,
   input  logic [SIDE_W-1:0] side_in,
   output logic out_valid,
   output logic [stcx_pkg::ROOT_BITS-1:0] root_a,
   output logic [stcx_pkg::REM_BITS-1:0]  rem_a,
   output logic [stcx_pkg::ROOT_BITS-1:0] root_b,
   output logic [SIDE_W-1:0] side_out
);
   localparam int N = stcx_pkg::ROOT_BITS;

   stcx_pkg::root_step_type a_ff [N];
   stcx_pkg::root_step_type b_ff [N];
   stcx_pkg::root_step_type a_src [N];
   stcx_pkg::root_step_type b_src [N];
   logic [SIDE_W-1:0] side_ff [N];
   logic [SIDE_W-1:0] side_src [N];
   logic v_ff [N];
   logic v_src [N];

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_stage
         if (i == 0) begin : g_first
            assign a_src[i]    = '{rad: rad_a, rem: '0, root: '0};
            assign b_src[i]    = '{rad: rad_b, rem: '0, root: '0};
            assign side_src[i] = side_in;
            assign v_src[i]    = in_valid;
         end else begin : g_next
            assign a_src[i]    = a_ff[i-1];
            assign b_src[i]    = b_ff[i-1];
            assign side_src[i] = side_ff[i-1];
            assign v_src[i]    = v_ff[i-1];
         end

         // advance valid bit
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[i] <= 1'b0;
            end else if (en) begin
               v_ff[i] <= v_src[i];
            end
         end

         // resolve one root digit in each lane
         always_ff @(posedge clock) begin
            if (en) begin
               a_ff[i]    <= stcx_pkg::sqrt_step(a_src[i]);
               b_ff[i]    <= stcx_pkg::sqrt_step(b_src[i]);
               side_ff[i] <= side_src[i];
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[N-1];
   assign root_a    = a_ff[N-1].root;
   assign rem_a     = a_ff[N-1].rem;
   assign root_b    = b_ff[N-1].root;
   assign side_out  = side_ff[N-1];
endmodule

[hdl/stcx_cordic.sv]
// Pipelined CORDIC vectoring, one rotation per stage, accumulating the angle.
module stcx_cordic #(
   parameter int SIDE_W = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic signed [stcx_pkg::CORDIC_W-1:0] x_in,
   input  logic signed [stcx_pkg::CORDIC_W-1:0] y_in,
   input  logic [SIDE_W-1:0] side_in,
   output logic out_valid,
   output logic signed [stcx_pkg::ACC_BITS-1:0] acc,
   output logic [SIDE_W-1:0] side_out
);
   localparam int N = stcx_pkg::CORDIC_STEPS;
   localparam int W = stcx_pkg::CORDIC_W;
   localparam int A = stcx_pkg::ACC_BITS;

   logic signed [W-1:0] x_ff [N];
   logic signed [W-1:0] y_ff [N];
   logic signed [A-1:0] acc_ff [N];
   logic signed [W-1:0] x_src [N];
   logic signed [W-1:0] y_src [N];
   logic signed [A-1:0] acc_src [N];
   logic signed [W-1:0] xs [N];
   logic signed [W-1:0] ys [N];
   logic [SIDE_W-1:0] side_ff [N];
   logic [SIDE_W-1:0] side_src [N];
   logic v_ff [N];
   logic v_src [N];

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_stage
         if (i == 0) begin : g_first
            assign x_src[i]    = x_in;
            assign y_src[i]    = y_in;
            assign acc_src[i]  = '0;
            assign side_src[i] = side_in;
            assign v_src[i]    = in_valid;
         end else begin : g_next
            assign x_src[i]    = x_ff[i-1];
            assign y_src[i]    = y_ff[i-1];
            assign acc_src[i]  = acc_ff[i-1];
            assign side_src[i] = side_ff[i-1];
            assign v_src[i]    = v_ff[i-1];
         end

         assign xs[i] = x_src[i] >>> i;
         assign ys[i] = y_src[i] >>> i;

         // advance valid bit
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[i] <= 1'b0;
            end else if (en) begin
               v_ff[i] <= v_src[i];
            end
         end

         // rotate toward the x axis by atan(2^-i)
         always_ff @(posedge clock) begin
            if (en) begin
               if (y_src[i] > 0) begin
                  x_ff[i]   <= x_src[i] + ys[i];
                  y_ff[i]   <= y_src[i] - xs[i];
                  acc_ff[i] <= acc_src[i] + stcx_pkg::ATAN_TAB[i];
               end else begin
                  x_ff[i]   <= x_src[i] - ys[i];
                  y_ff[i]   <= y_src[i] + xs[i];
                  acc_ff[i] <= acc_src[i] - stcx_pkg::ATAN_TAB[i];
               end
               side_ff[i] <= side_src[i];
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[N-1];
   assign acc       = acc_ff[N-1];
   assign side_out  = side_ff[N-1];
endmodule

[hdl/stcx_checker.sv]
// Port-level checks for the segment-to-cylinder transform, bound to the top level.
module stcx_checker #(
   parameter int COORD_BITS = 24
) (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [COORD_BITS:0] rsp_length,
   input logic signed [15:0] rsp_angle,
   input logic signed [2*COORD_BITS+1:0] rsp_axis_x,
   input logic signed [2*COORD_BITS+1:0] rsp_axis_y,
   input logic rsp_degenerate
);
   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // a zero-length segment gives an all-zero placement
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_length == '0 && rsp_angle == '0 && rsp_axis_x == '0 && rsp_axis_y == '0)
      else $error("degenerate segment with nonzero placement");

   // keep the angle within half a turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle >= -16'sd23040 && rsp_angle <= 16'sd23040)
      else $error("angle out of range");

   // drain the pipeline on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind segment_to_cylinder_transform stcx_checker #(.COORD_BITS(COORD_BITS)) u_stcx_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_length(rsp_bus.length),
   .rsp_angle(rsp_bus.angle),
   .rsp_axis_x(rsp_bus.axis_x),
   .rsp_axis_y(rsp_bus.axis_y),
   .rsp_degenerate(rsp_bus.degenerate)
);
